// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TGAD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define TGAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tgad_pkg.sv =====
// Types and constants shared by the truecolor image stream decoder.
package tgad_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PIXEL   = 3'd0,
        KIND_HDR_OK  = 3'd1,
        KIND_HDR_BAD = 3'd2,
        KIND_SHORT   = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] color;
        logic [31:0] pixel_index;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        file_end;
    } t_result;

    localparam int DATA_W  = 96;
    localparam int KIND_W  = 3;

    localparam logic [4:0] HDR_IDX_TYPE      = 5'd2;
    localparam logic [4:0] HDR_IDX_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_IDX_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_IDX_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_IDX_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_IDX_BPP       = 5'd16;
    localparam logic [4:0] HDR_IDX_DESC      = 5'd17;

    localparam logic [7:0] IMAGE_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] BPP_ALPHA            = 8'd32;
    localparam logic [7:0] BPP_RGB              = 8'd24;
    localparam logic [7:0] DESC_ALPHA           = 8'd8;
    localparam logic [7:0] DESC_RGB             = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE         = 8'hFF;

    localparam logic [1:0] BP_FINAL_ALPHA = 2'd3;
    localparam logic [1:0] BP_FINAL_RGB   = 2'd2;

endpackage

// ===== sv/tgad_core.sv =====
// Header check, pixel assembly and destination index state for one byte per cycle while i_accept is high.
module tgad_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output tgad_pkg::t_result o_res
);
    import tgad_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_hdr_ok, n_hdr_ok;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_has_alpha, n_has_alpha;
    logic [1:0]  r_bp, n_bp;
    logic [23:0] r_partial, n_partial;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [31:0] r_row_base, n_row_base;
    logic [31:0] r_prod, n_prod;

    logic        hdr_bad_byte;
    logic        ok_now;
    logic        hdr_end;
    logic        img_empty;
    logic [1:0]  final_bp;
    logic        pix_done;
    logic        last_pix;
    logic        row_end;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic [15:0] height_m1;
    logic [23:0] pix_rgb;
    logic [7:0]  alpha;

    assign height_m1 = r_height - 16'd1;
    assign n_prod    = height_m1 * r_width;
    assign hdr_end   = (r_hdr_cnt == HDR_IDX_DESC);
    assign img_empty = (r_width == 16'd0) || (r_height == 16'd0);
    assign ok_now    = r_hdr_ok & ~hdr_bad_byte;
    assign final_bp  = r_has_alpha ? BP_FINAL_ALPHA : BP_FINAL_RGB;
    assign pix_done  = (r_bp >= final_bp);
    assign col_inc   = {1'b0, r_col} + 17'd1;
    assign row_inc   = {1'b0, r_row} + 17'd1;
    assign row_end   = (col_inc == {1'b0, r_width});
    assign last_pix  = row_end && (row_inc == {1'b0, r_height});
    assign alpha     = r_has_alpha ? i_byte : ALPHA_OPAQUE;

    always_comb begin
        hdr_bad_byte = 1'b0;
        priority if (r_hdr_cnt == HDR_IDX_TYPE) begin
            hdr_bad_byte = (i_byte != IMAGE_TYPE_TRUECOLOR);
        end else if (r_hdr_cnt < HDR_IDX_WIDTH_LO) begin
            hdr_bad_byte = (i_byte != 8'd0);
        end else if (r_hdr_cnt == HDR_IDX_BPP) begin
            hdr_bad_byte = (i_byte != BPP_ALPHA) && (i_byte != BPP_RGB);
        end else if (r_hdr_cnt == HDR_IDX_DESC) begin
            hdr_bad_byte = (i_byte != (r_has_alpha ? DESC_ALPHA : DESC_RGB));
        end else begin
            hdr_bad_byte = 1'b0;
        end
    end

    always_comb begin
        unique case (r_bp)
            2'd0:    pix_rgb = {i_byte, 16'd0};
            2'd1:    pix_rgb = {r_partial[23:16], i_byte, 8'd0};
            2'd2:    pix_rgb = {r_partial[23:8], i_byte};
            default: pix_rgb = r_partial;
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_last) begin
                n_phase = PH_HEADER;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (hdr_end) begin
                            n_phase = (!ok_now || img_empty) ? PH_SKIP : PH_PIXELS;
                        end
                    end
                    PH_PIXELS: begin
                        if (pix_done && last_pix) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    default: n_phase = PH_SKIP;
                endcase
            end
        end
    end

    // Result for the current transaction.
    always_comb begin
        o_res = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    priority if (!hdr_end) begin
                        o_res.valid    = i_last;
                        o_res.kind     = KIND_SHORT;
                        o_res.file_end = 1'b1;
                    end else if (!ok_now) begin
                        o_res.valid    = 1'b1;
                        o_res.kind     = KIND_HDR_BAD;
                        o_res.file_end = i_last;
                    end else if (img_empty || !i_last) begin
                        o_res.valid        = 1'b1;
                        o_res.kind         = KIND_HDR_OK;
                        o_res.image_width  = r_width;
                        o_res.image_height = r_height;
                        o_res.file_end     = i_last;
                    end else begin
                        o_res.valid    = 1'b1;
                        o_res.kind     = KIND_SHORT;
                        o_res.file_end = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    priority if (!pix_done || (i_last && !last_pix)) begin
                        o_res.valid    = i_last;
                        o_res.kind     = KIND_SHORT;
                        o_res.file_end = 1'b1;
                    end else begin
                        o_res.valid       = 1'b1;
                        o_res.kind        = KIND_PIXEL;
                        o_res.color       = {alpha, pix_rgb};
                        o_res.pixel_index = r_row_base + {16'd0, r_col};
                        o_res.file_end    = i_last;
                    end
                end
                default: begin
                    o_res.valid    = i_last;
                    o_res.kind     = KIND_END;
                    o_res.file_end = 1'b1;
                end
            endcase
        end
    end

    // Counters and header fields.
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_ok    = r_hdr_ok;
        n_width     = r_width;
        n_height    = r_height;
        n_has_alpha = r_has_alpha;
        n_bp        = r_bp;
        n_partial   = r_partial;
        n_col       = r_col;
        n_row       = r_row;
        n_row_base  = r_row_base;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr_ok = ok_now;
                    if (r_hdr_cnt == HDR_IDX_WIDTH_LO) begin
                        n_width = {8'd0, i_byte};
                    end
                    if (r_hdr_cnt == HDR_IDX_WIDTH_HI) begin
                        n_width = {i_byte, r_width[7:0]};
                    end
                    if (r_hdr_cnt == HDR_IDX_HEIGHT_LO) begin
                        n_height = {8'd0, i_byte};
                    end
                    if (r_hdr_cnt == HDR_IDX_HEIGHT_HI) begin
                        n_height = {i_byte, r_height[7:0]};
                    end
                    if (r_hdr_cnt == HDR_IDX_BPP) begin
                        n_has_alpha = (i_byte == BPP_ALPHA);
                    end
                    if (!hdr_end) begin
                        n_hdr_cnt = r_hdr_cnt + 5'd1;
                    end else begin
                        n_row_base = r_prod;
                        n_col      = 16'd0;
                        n_row      = 16'd0;
                        n_bp       = 2'd0;
                        n_partial  = 24'd0;
                    end
                end
                PH_PIXELS: begin
                    n_partial = pix_rgb;
                    if (!pix_done) begin
                        n_bp = r_bp + 2'd1;
                    end else begin
                        n_bp = 2'd0;
                        if (!last_pix) begin
                            if (row_end) begin
                                n_col      = 16'd0;
                                n_row      = row_inc[15:0];
                                n_row_base = r_row_base - {16'd0, r_width};
                            end else begin
                                n_col = col_inc[15:0];
                            end
                        end
                    end
                end
                default: begin
                    n_bp = r_bp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= 5'd0;
            r_hdr_ok    <= 1'b1;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_has_alpha <= 1'b0;
            r_bp        <= 2'd0;
            r_partial   <= 24'd0;
            r_col       <= 16'd0;
            r_row       <= 16'd0;
            r_row_base  <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_ok    <= n_hdr_ok;
            r_width     <= n_width;
            r_height    <= n_height;
            r_has_alpha <= n_has_alpha;
            r_bp        <= n_bp;
            r_partial   <= n_partial;
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_base  <= n_row_base;
        end
    end

endmodule

// ===== sv/tgad_out_stage.sv =====
// Output register that holds one result until the downstream side takes it.
module tgad_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tgad_pkg::t_result i_res,
    input  logic              i_m_tready,
    output logic              o_in_ready,
    output logic              o_valid,
    output tgad_pkg::t_result o_res
);
    import tgad_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_in_ready = !r_valid || i_m_tready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_accept && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_res.valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/tga_truecolor_stream_decoder.sv =====
// Streaming decoder for uncompressed truecolor TGA files, one file byte per transaction.
// The block takes one byte in every clock cycle unless the output register stalls; each
// result appears on the master side in the cycle after the byte that causes it, and the
// slave side stalls only while the single output register holds a result not yet taken.
// The first 18 bytes are the header; it produces an accepted or rejected result, and
// each complete 3 or 4 byte pixel produces a packed color with its bottom-up destination
// index. A file that ends early produces a too-short result, so pixels already sent for
// that file must be dropped. Every result that carries tlast leaves the block ready for
// the next file. The row base multiply is registered and settles during the header.
module tga_truecolor_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // file_byte [7:0]
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [tgad_pkg::DATA_W-1:0] o_m_axis_tdata,
    // color [31:0], pixel_index [63:32], image_width [79:64], image_height [95:80]
    output logic [tgad_pkg::KIND_W-1:0] o_m_axis_tuser,  // kind [2:0]
    output logic        o_m_axis_tlast    // file_end
);
    import tgad_pkg::*;

    logic    accept;
    t_result core_res;
    t_result out_res;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    tgad_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_res    (core_res)
    );

    tgad_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_res      (core_res),
        .i_m_tready (i_m_axis_tready),
        .o_in_ready (o_s_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (out_res)
    );

    assign o_m_axis_tdata = {out_res.image_height, out_res.image_width,
                             out_res.pixel_index, out_res.color};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.file_end;

endmodule

// ===== sv/tgad_checker.sv =====
// Port-level assertions for the decoder, bound to its top level.
`include "assert_macros.svh"

module tgad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [tgad_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic [tgad_pkg::KIND_W-1:0] o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import tgad_pkg::*;

    `TGAD_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "Stalled output transaction changed.")

    `TGAD_ASSERT_SAME(a_no_overrun, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready,
        "Input accepted while the output register is stalled.")

    `TGAD_ASSERT_SAME(a_pixel_fields, o_m_axis_tvalid && (o_m_axis_tuser != KIND_PIXEL),
        o_m_axis_tdata[63:0] == 64'd0, "Non-pixel result carries color or index.")

    `TGAD_ASSERT_SAME(a_size_fields, o_m_axis_tvalid && (o_m_axis_tuser != KIND_HDR_OK),
        o_m_axis_tdata[95:64] == 32'd0, "Size fields set outside a header result.")

    `TGAD_ASSERT_SAME(a_end_kinds,
        o_m_axis_tvalid && ((o_m_axis_tuser == KIND_SHORT) || (o_m_axis_tuser == KIND_END)),
        o_m_axis_tlast, "Short or end result without the end-of-file flag.")

endmodule

bind tga_truecolor_stream_decoder tgad_checker u_tgad_checker (.*);

// ===== test/tb_tga_truecolor_stream_decoder.sv =====
// Testbench for the truecolor TGA stream decoder: directed files, then random files.
`timescale 1ns / 100ps

module tb_tga_truecolor_stream_decoder;
    import tgad_pkg::*;

    localparam logic [4:0] NO_FAULT = 5'd31;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        logic [7:0]  desc;
        logic [4:0]  bad_idx;
        logic [7:0]  bad_val;
        logic [7:0]  len;
        logic [7:0]  fill;
        logic [7:0]  mask;
        logic        typed;
        t_kind       end_kind;
    } t_case;

    // Each row is one file: header fields, an optional corrupted header byte, the file
    // length and the data pattern. Rows with typed set carry the final result's kind.
    localparam t_case DIRECTED [24] = '{
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd1, 8'h00, 8'h00, 1'b1, KIND_SHORT},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd10, 8'h00, 8'h00, 1'b1, KIND_SHORT},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd17, 8'h00, 8'h00, 1'b1, KIND_SHORT},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, HDR_IDX_TYPE, 8'h03, 8'd18, 8'h00, 8'h00, 1'b1,
          KIND_HDR_BAD},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, 5'd0, 8'hFF, 8'd25, 8'h00, 8'hFF, 1'b1, KIND_END},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, 5'd7, 8'h80, 8'd20, 8'h00, 8'hFF, 1'b1, KIND_END},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, 5'd11, 8'h01, 8'd18, 8'h00, 8'h00, 1'b1, KIND_HDR_BAD},
        '{16'd2, 16'd2, 8'd16, DESC_RGB, NO_FAULT, 8'h00, 8'd19, 8'h00, 8'hFF, 1'b1, KIND_END},
        '{16'd2, 16'd2, BPP_ALPHA, DESC_RGB, NO_FAULT, 8'h00, 8'd18, 8'h00, 8'h00, 1'b1,
          KIND_HDR_BAD},
        '{16'd2, 16'd2, BPP_RGB, DESC_ALPHA, NO_FAULT, 8'h00, 8'd18, 8'h00, 8'h00, 1'b1,
          KIND_HDR_BAD},
        '{16'd0, 16'd5, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd22, 8'h00, 8'hFF, 1'b1, KIND_END},
        '{16'd7, 16'd0, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd18, 8'h00, 8'h00, 1'b0, KIND_PIXEL},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd18, 8'h00, 8'h00, 1'b1, KIND_SHORT},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd22, 8'h00, 8'hFF, 1'b1, KIND_SHORT},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd24, 8'h00, 8'hFF, 1'b1, KIND_SHORT},
        '{16'd3, 16'd2, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd36, 8'h00, 8'h00, 1'b0, KIND_PIXEL},
        '{16'd2, 16'd2, BPP_ALPHA, DESC_ALPHA, NO_FAULT, 8'h00, 8'd34, 8'hFF, 8'h00, 1'b0,
          KIND_PIXEL},
        '{16'd1, 16'd3, BPP_ALPHA, DESC_ALPHA, NO_FAULT, 8'h00, 8'd34, 8'h00, 8'hFF, 1'b1,
          KIND_END},
        '{16'hFFFF, 16'hFFFF, BPP_ALPHA, DESC_ALPHA, NO_FAULT, 8'h00, 8'd32, 8'h00, 8'hFF, 1'b1,
          KIND_SHORT},
        '{16'hFFFF, 16'd1, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd27, 8'h00, 8'hFF, 1'b1,
          KIND_SHORT},
        '{16'd1, 16'hFFFF, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd29, 8'h00, 8'hFF, 1'b1,
          KIND_SHORT},
        '{16'd4, 16'd3, BPP_RGB, DESC_RGB, NO_FAULT, 8'h00, 8'd54, 8'h00, 8'hFF, 1'b0, KIND_PIXEL},
        '{16'd2, 16'd2, BPP_RGB, DESC_RGB, HDR_IDX_DESC, 8'h20, 8'd18, 8'h00, 8'h00, 1'b1,
          KIND_HDR_BAD},
        '{16'd1, 16'd1, BPP_ALPHA, DESC_ALPHA, NO_FAULT, 8'h00, 8'd22, 8'h00, 8'hFF, 1'b0,
          KIND_PIXEL}
    };

    logic                i_clk;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [7:0]          s_data = 8'h00;
    logic                s_last = 1'b0;
    logic                m_tready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [DATA_W-1:0]   o_m_axis_tdata;
    logic [KIND_W-1:0]   o_m_axis_tuser;
    logic                o_m_axis_tlast;

    t_phase      dec_phase;
    logic [4:0]  hdr_count;
    logic        hdr_good;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        alpha_mode;
    logic [1:0]  pix_byte;
    logic [23:0] rgb_acc;
    logic [15:0] col_cnt;
    logic [15:0] row_cnt;
    logic [31:0] base_idx;

    t_result     pending_results[$];
    t_result     want;
    logic [7:0]  file_bytes[$];
    int          mismatches = 0;
    int          useful_bytes = 0;
    int          src_idle_pct = 11;
    int          sink_stall_pct = 63;

    tga_truecolor_stream_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_result result_of(input t_kind kind, input logic [31:0] color,
                                          input logic [31:0] idx, input logic [15:0] w,
                                          input logic [15:0] h, input logic fe);
        t_result r;
        r.valid        = 1'b1;
        r.kind         = kind;
        r.color        = color;
        r.pixel_index  = idx;
        r.image_width  = w;
        r.image_height = h;
        r.file_end     = fe;
        return r;
    endfunction

    function automatic void restart_file();
        dec_phase  = PH_HEADER;
        hdr_count  = 5'd0;
        hdr_good   = 1'b1;
        img_w      = 16'd0;
        img_h      = 16'd0;
        alpha_mode = 1'b0;
        pix_byte   = 2'd0;
        rgb_acc    = 24'd0;
        col_cnt    = 16'd0;
        row_cnt    = 16'd0;
        base_idx   = 32'd0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_result res);
        logic [4:0]  n;
        logic [1:0]  final_bp;
        logic        last_pix;
        logic [31:0] rows_above;
        logic [31:0] wide;
        res = result_of(KIND_PIXEL, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        if (dec_phase == PH_HEADER) begin
            n = hdr_count;
            if (n < HDR_IDX_WIDTH_LO && n != HDR_IDX_TYPE) begin
                if (b != 8'd0) hdr_good = 1'b0;
            end else if (n == HDR_IDX_TYPE) begin
                if (b != IMAGE_TYPE_TRUECOLOR) hdr_good = 1'b0;
            end else if (n == HDR_IDX_WIDTH_LO) begin
                img_w = {8'd0, b};
            end else if (n == HDR_IDX_WIDTH_HI) begin
                img_w[15:8] = b;
            end else if (n == HDR_IDX_HEIGHT_LO) begin
                img_h = {8'd0, b};
            end else if (n == HDR_IDX_HEIGHT_HI) begin
                img_h[15:8] = b;
            end else if (n == HDR_IDX_BPP) begin
                if (b == BPP_ALPHA) begin
                    alpha_mode = 1'b1;
                end else begin
                    alpha_mode = 1'b0;
                    if (b != BPP_RGB) hdr_good = 1'b0;
                end
            end else begin
                if (b != (alpha_mode ? DESC_ALPHA : DESC_RGB)) hdr_good = 1'b0;
            end
            if (n < HDR_IDX_DESC) begin
                hdr_count = n + 5'd1;
                if (last) begin
                    res = result_of(KIND_SHORT, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
                    restart_file();
                    return 1'b1;
                end
                return 1'b0;
            end
            if (!hdr_good || img_w == 16'd0 || img_h == 16'd0) begin
                if (!hdr_good) res = result_of(KIND_HDR_BAD, 32'd0, 32'd0, 16'd0, 16'd0, last);
                else res = result_of(KIND_HDR_OK, 32'd0, 32'd0, img_w, img_h, last);
                if (last) restart_file();
                else dec_phase = PH_SKIP;
                return 1'b1;
            end
            if (last) begin
                res = result_of(KIND_SHORT, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
                restart_file();
                return 1'b1;
            end
            rows_above = {16'd0, img_h} - 32'd1;
            wide       = {16'd0, img_w};
            base_idx   = rows_above * wide;
            col_cnt    = 16'd0;
            row_cnt    = 16'd0;
            pix_byte   = 2'd0;
            rgb_acc    = 24'd0;
            dec_phase  = PH_PIXELS;
            res = result_of(KIND_HDR_OK, 32'd0, 32'd0, img_w, img_h, 1'b0);
            return 1'b1;
        end
        if (dec_phase == PH_PIXELS) begin
            final_bp = alpha_mode ? BP_FINAL_ALPHA : BP_FINAL_RGB;
            if (pix_byte == 2'd0) rgb_acc = {b, 16'd0};
            else if (pix_byte == 2'd1) rgb_acc[15:8] = b;
            else if (pix_byte == 2'd2) rgb_acc[7:0] = b;
            if (pix_byte < final_bp) begin
                pix_byte = pix_byte + 2'd1;
                if (last) begin
                    res = result_of(KIND_SHORT, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
                    restart_file();
                    return 1'b1;
                end
                return 1'b0;
            end
            last_pix = (col_cnt + 32'd1 == img_w) && (row_cnt + 32'd1 == img_h);
            if (last && !last_pix) begin
                res = result_of(KIND_SHORT, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
                restart_file();
                return 1'b1;
            end
            res = result_of(KIND_PIXEL, {alpha_mode ? b : ALPHA_OPAQUE, rgb_acc},
                            base_idx + {16'd0, col_cnt}, 16'd0, 16'd0, last);
            pix_byte = 2'd0;
            if (last_pix) begin
                if (last) restart_file();
                else dec_phase = PH_SKIP;
            end else if (col_cnt + 32'd1 >= img_w) begin
                col_cnt  = 16'd0;
                row_cnt  = row_cnt + 16'd1;
                base_idx = base_idx - {16'd0, img_w};
            end else begin
                col_cnt = col_cnt + 16'd1;
            end
            return 1'b1;
        end
        if (last) begin
            res = result_of(KIND_END, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
            restart_file();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, kind %0d", o_m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_m_axis_tuser);
                check_field("color", want.color, o_m_axis_tdata[31:0]);
                check_field("pixel_index", want.pixel_index, o_m_axis_tdata[63:32]);
                check_field("image_width", want.image_width, o_m_axis_tdata[79:64]);
                check_field("image_height", want.image_height, o_m_axis_tdata[95:80]);
                check_field("file_end", want.file_end, o_m_axis_tlast);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_kind typed_kind);
        t_result res;
        bit      produced;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (dec_phase != PH_SKIP) useful_bytes++;
        produced = decode_byte(b, last, res);
        if (typed && last) begin
            res = result_of(typed_kind, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
            produced = 1'b1;
        end
        if (produced) pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic send_file(input logic typed, input t_kind typed_kind);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1, typed, typed_kind);
        file_bytes.delete();
    endtask

    task automatic build_header(input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] bpp, input logic [7:0] desc);
        file_bytes.delete();
        for (int k = 0; k < 18; k++) file_bytes.push_back(8'h00);
        file_bytes[HDR_IDX_TYPE]      = IMAGE_TYPE_TRUECOLOR;
        file_bytes[HDR_IDX_WIDTH_LO]  = w[7:0];
        file_bytes[HDR_IDX_WIDTH_HI]  = w[15:8];
        file_bytes[HDR_IDX_HEIGHT_LO] = h[7:0];
        file_bytes[HDR_IDX_HEIGHT_HI] = h[15:8];
        file_bytes[HDR_IDX_BPP]       = bpp;
        file_bytes[HDR_IDX_DESC]      = desc;
    endtask

    task automatic fill_to(input longint len, input logic [7:0] fill, input logic [7:0] mask);
        while (file_bytes.size() < len) file_bytes.push_back(fill ^ (8'($urandom) & mask));
        while (file_bytes.size() > len) void'(file_bytes.pop_back());
    endtask

    // Mostly complete files with random pixels; the rest are cut short, carry a corrupted
    // header byte, or are plain noise.
    task automatic random_file();
        int          sel;
        int          bpb;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        longint      data_n;
        longint      len;
        sel = $urandom_range(99);
        bpp = $urandom_range(1) ? BPP_ALPHA : BPP_RGB;
        bpb = (bpp == BPP_ALPHA) ? 4 : 3;
        if ($urandom_range(19) == 0) begin
            w = 16'($urandom);
            h = 16'($urandom);
        end else begin
            w = 16'($urandom_range(6, 1));
            h = 16'($urandom_range(4, 1));
            if ($urandom_range(14) == 0) begin
                if ($urandom_range(1)) w = 16'd0;
                else h = 16'd0;
            end
        end
        data_n = w;
        data_n = data_n * h * bpb;
        build_header(w, h, bpp, (bpp == BPP_ALPHA) ? DESC_ALPHA : DESC_RGB);
        len = 18 + data_n;
        if (sel < 70) begin
            if ($urandom_range(1)) len += $urandom_range(3, 1);
        end else if (sel < 84) begin
            if (len > 80) len = 80;
            len = $urandom_range(len - 1, 1);
        end else if (sel < 94) begin
            file_bytes[$urandom_range(17)] = 8'($urandom);
            len = 18 + $urandom_range(6);
        end else begin
            for (int k = 0; k < 18; k++) file_bytes[k] = 8'($urandom);
            len = $urandom_range(30, 1);
        end
        if (len > 200) len = 18 + $urandom_range(60);
        fill_to(len, 8'h00, 8'hFF);
        send_file(1'b0, KIND_PIXEL);
    endtask

    initial begin
        t_case cur;
        restart_file();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            cur = DIRECTED[i];
            build_header(cur.w, cur.h, cur.bpp, cur.desc);
            if (cur.bad_idx != NO_FAULT) file_bytes[cur.bad_idx] = cur.bad_val;
            fill_to(cur.len, cur.fill, cur.mask);
            send_file(cur.typed, cur.end_kind);
        end

        useful_bytes = 0;
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct   = (ph == 0) ? 11 : (ph == 1) ? 63 : 0;
            sink_stall_pct = (ph == 0) ? 63 : (ph == 1) ? 11 : 0;
            // Hold the sender off until every outstanding result has drained.
            s_valid <= 1'b0;
            @(negedge i_clk);
            while (pending_results.size() != 0) @(negedge i_clk);
            while (useful_bytes < (ph + 1) * 200) random_file();
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tgad_pkg.sv
sv/tgad_core.sv
sv/tgad_out_stage.sv
sv/tga_truecolor_stream_decoder.sv
sv/tgad_checker.sv
test/tb_tga_truecolor_stream_decoder.sv
